>>> rtl/alarm_setting_controller_macros.svh
// Assertion helpers; the using scope provides clk and arst_n.
`ifndef ALARM_SETTING_CONTROLLER_MACROS_SVH
`define ALARM_SETTING_CONTROLLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/asc_pkg.sv
package asc_pkg;

	localparam int ASC_DEBOUNCE_SAMPLES = 15;

	localparam logic CMD_TICK   = 1'b0;
	localparam logic CMD_SERIAL = 1'b1;

	localparam logic [1:0] BTN_RIGHT = 2'b01;
	localparam logic [1:0] BTN_LEFT  = 2'b10;

	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_HOUR    = 3'd1;
	localparam logic [2:0] MODE_MINUTE  = 3'd2;
	localparam logic [2:0] MODE_ARMED   = 3'd3;
	localparam logic [2:0] MODE_RINGING = 3'd4;

	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_1 = 8'h31;
	localparam logic [7:0] CH_2 = 8'h32;
	localparam logic [7:0] CH_3 = 8'h33;
	localparam logic [7:0] CH_4 = 8'h34;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_A = 8'h61;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_O = 8'h6F;

	typedef struct packed {
		logic       command;
		logic [1:0] buttons_raw;
		logic [7:0] rx_byte;
	} asc_in_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [1:0] hour_tens;
		logic [3:0] hour_ones;
		logic [2:0] minute_tens;
		logic [3:0] minute_ones;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       tone_on;
		logic [1:0] stable_buttons;
	} asc_out_t;

endpackage

>>> rtl/asc_in_if.sv
interface asc_in_if import asc_pkg::*; ();
	logic    valid;
	logic    ready;
	asc_in_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/asc_out_if.sv
interface asc_out_if import asc_pkg::*; ();
	logic     valid;
	logic     ready;
	asc_out_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/alarm_setting_controller.sv
// An item transfer loads the input register; the item's result is computed
// combinationally and loaded into the output register when that can advance.
// One item per cycle while the result is not stalled; the input register and
// the result register each hold one item, so a stalled result still lets one
// more item in. The combinational state update between them sets this rate.
// Reset (arst_n low) clears debounce counters, mode, digits, tone and valids.
`include "alarm_setting_controller_macros.svh"

module alarm_setting_controller import asc_pkg::*; #(
	parameter int DEBOUNCE_SAMPLES = ASC_DEBOUNCE_SAMPLES
) (
	input  logic      clk,
	input  logic      arst_n,
	asc_in_if.sink    item,
	asc_out_if.source result
);

	localparam int CW = $clog2(DEBOUNCE_SAMPLES + 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEBOUNCE_SAMPLES);

	logic            v_s1;
	asc_in_t         in_s1;
	logic            adv;
	logic            out_valid_q;
	asc_out_t        result_q;

	// Per-button run length of consecutive pressed samples, saturating at the
	// window depth: all samples in the window pressed <=> run reached the depth.
	logic [1:0][CW-1:0] cnt_q, cnt_d;
	logic [1:0]      deb_q, deb_d;
	logic [2:0]      mode_q, mode_d;
	logic [1:0]      ht_q, ht_d;
	logic [3:0]      ho_q, ho_d;
	logic [2:0]      mt_q, mt_d;
	logic [3:0]      mo_q, mo_d;
	logic            tone_q, tone_d;
	logic            tx_v;
	logic [7:0]      tx_b;
	logic            left, right;

	logic [4:0]      ho_sum;
	logic [2:0]      ht_sum;
	logic [3:0]      ho_bump;
	logic [1:0]      ht_bump;
	logic [4:0]      mo_sum;
	logic [3:0]      mo_bump;
	logic [2:0]      mt_bump;

	assign adv        = !out_valid_q || result.ready;
	assign item.ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item.ready) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			in_s1 <= item.payload;
		end
	end

	// Hour increment with wrap at 24
	always_comb begin
		ho_sum = {1'b0, ho_q} + 5'd1;
		if (ho_sum >= 5'd10) begin
			ho_bump = 4'd0;
			ht_sum  = {1'b0, ht_q} + 3'd1;
		end else begin
			ho_bump = ho_sum[3:0];
			ht_sum  = {1'b0, ht_q};
		end
		if ((ht_sum == 3'd2 && ho_bump >= 4'd4) || ht_sum > 3'd2) begin
			ht_bump = 2'd0;
			ho_bump = 4'd0;
		end else begin
			ht_bump = ht_sum[1:0];
		end
	end

	// Minute increment with wrap at 60
	always_comb begin
		mo_sum = {1'b0, mo_q} + 5'd1;
		if (mo_sum >= 5'd10) begin
			mo_bump = 4'd0;
			mt_bump = mt_q + 3'd1;
		end else begin
			mo_bump = mo_sum[3:0];
			mt_bump = mt_q;
		end
		if (mt_bump >= 3'd6) begin
			mt_bump = 3'd0;
		end
	end

	always_comb begin
		cnt_d  = cnt_q;
		deb_d  = deb_q;
		mode_d = mode_q;
		ht_d   = ht_q;
		ho_d   = ho_q;
		mt_d   = mt_q;
		mo_d   = mo_q;
		tone_d = tone_q;
		tx_v   = 1'b0;
		tx_b   = 8'd0;
		left   = 1'b0;
		right  = 1'b0;
		if (in_s1.command == CMD_TICK) begin
			for (int b = 0; b < 2; b++) begin
				if (in_s1.buttons_raw[b]) begin
					cnt_d[b] = (cnt_q[b] == CNT_FULL) ? CNT_FULL : cnt_q[b] + 1'b1;
				end else begin
					cnt_d[b] = '0;
				end
			end
			deb_d = {cnt_d[1] == CNT_FULL, cnt_d[0] == CNT_FULL};
			left  = (deb_d == BTN_LEFT);
			right = (deb_d == BTN_RIGHT);
			// A press counts only after a tick with nothing stable
			if (deb_q == 2'b00) begin
				unique case (mode_q)
					MODE_IDLE: begin
						if (left) mode_d = MODE_HOUR;
					end
					MODE_HOUR: begin
						if (right) begin
							ht_d = ht_bump;
							ho_d = ho_bump;
						end else if (left) begin
							mode_d = MODE_MINUTE;
						end
					end
					MODE_MINUTE: begin
						if (right) begin
							mt_d = mt_bump;
							mo_d = mo_bump;
						end else if (left) begin
							tx_v   = 1'b1;
							tx_b   = CH_R;
							mode_d = MODE_ARMED;
						end
					end
					MODE_ARMED: begin
						if (left) begin
							tx_v   = 1'b1;
							tx_b   = CH_S;
							mode_d = MODE_IDLE;
						end
					end
					MODE_RINGING: begin
						if (left) begin
							tx_v   = 1'b1;
							tx_b   = CH_O;
							tone_d = 1'b0;
							mode_d = MODE_IDLE;
						end
					end
					default: begin
					end
				endcase
			end
		end else begin
			priority if (in_s1.rx_byte == CH_1) begin
				tx_v = 1'b1;
				tx_b = CH_0;
			end else if (in_s1.rx_byte == CH_2) begin
				tx_v = 1'b1;
				tx_b = CH_9;
			end else if (in_s1.rx_byte == CH_3) begin
				tx_v = 1'b1;
				tx_b = CH_0;
			end else if (in_s1.rx_byte == CH_4) begin
				tx_v = 1'b1;
				tx_b = CH_1;
			end else if (in_s1.rx_byte == CH_A && mode_q == MODE_ARMED) begin
				tone_d = 1'b1;
				mode_d = MODE_RINGING;
			end else begin
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			deb_q  <= 2'b00;
			mode_q <= MODE_IDLE;
			ht_q   <= 2'd0;
			ho_q   <= 4'd0;
			mt_q   <= 3'd0;
			mo_q   <= 4'd0;
			tone_q <= 1'b0;
		end else if (v_s1 && adv) begin
			cnt_q  <= cnt_d;
			deb_q  <= deb_d;
			mode_q <= mode_d;
			ht_q   <= ht_d;
			ho_q   <= ho_d;
			mt_q   <= mt_d;
			mo_q   <= mo_d;
			tone_q <= tone_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && adv) begin
			result_q.mode           <= mode_d;
			result_q.hour_tens      <= ht_d;
			result_q.hour_ones      <= ho_d;
			result_q.minute_tens    <= mt_d;
			result_q.minute_ones    <= mo_d;
			result_q.tx_valid       <= tx_v;
			result_q.tx_byte        <= tx_b;
			result_q.tone_on        <= tone_d;
			result_q.stable_buttons <= deb_d;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.payload = result_q;

	`ASC_ASSERT_NOW(a_tone_tracks_ringing, 1'b1, tone_q == (mode_q == MODE_RINGING),
		"tone and ringing mode disagree")
	`ASC_ASSERT_NOW(a_digits_in_range, 1'b1,
		((ht_q < 2'd2 && ho_q <= 4'd9) || (ht_q == 2'd2 && ho_q <= 4'd3))
		&& mt_q <= 3'd5 && mo_q <= 4'd9,
		"alarm digits out of range")
	`ASC_ASSERT_NEXT(a_single_action, 1'b1,
		$stable(mode_q) || ($stable(ht_q) && $stable(ho_q) && $stable(mt_q) && $stable(mo_q)),
		"mode and digits changed by one item")
	`ASC_ASSERT_NEXT(a_result_follows, v_s1 && adv, out_valid_q, "advanced item produced no result")

endmodule
